// File: hdl/fwh_pkg.sv
// Shared types, widths and codes for the fixed-width histogram engine.
package fwh_pkg;

  // Default sizing of the bin store
  localparam int NUM_BINS_DEF    = 1024;
  localparam int COUNT_WIDTH_DEF = 32;

  // Item field widths
  localparam int OPCODE_W = 2;
  localparam int VALUE_W  = 32;
  localparam int RDBIN_W  = 10;
  localparam int STATUS_W = 2;
  localparam int INDEX_W  = 10;
  localparam int COUNT_W  = 32;
  localparam int USED_W   = 11;

  // Register port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic [0:0] REG_BIN_WIDTH = 1'b0;
  localparam logic [APB_DW-1:0] BIN_WIDTH_RST = 32'h0001_0000;

  typedef enum logic [OPCODE_W-1:0] {
    OP_INSERT = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_READ   = 2'd2
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_BEYOND = 2'd1,
    ST_NEG    = 2'd2,
    ST_UNUSED = 2'd3
  } status_e;

  // Which kind of result the datapath loads into its output register
  typedef enum logic [1:0] {
    RES_INS  = 2'd0,
    RES_READ = 2'd1,
    RES_FLAG = 2'd2
  } res_kind_e;

  // Controller to datapath
  typedef struct packed {
    logic      capture;
    logic      div_start;
    logic      mem_rd;
    logic      rd_sel_read;
    logic      upd;
    logic      sweep;
    logic      clr_state;
    logic      res_load;
    res_kind_e res_kind;
    status_e   res_status;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [OPCODE_W-1:0] op;
    logic                neg;
    logic                div_done;
    logic                beyond;
    logic                sweep_last;
    logic                out_free;
  } stat_t;

endpackage

// File: hdl/fwh_if.sv
// Valid/ready channel interfaces for input items and result items.
interface fwh_in_if;
  import fwh_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [OPCODE_W-1:0]        opcode;
  logic signed [VALUE_W-1:0]  sample_value;
  logic [RDBIN_W-1:0]         read_bin;

  modport source (output valid, opcode, sample_value, read_bin, input ready);
  modport sink   (input valid, opcode, sample_value, read_bin, output ready);
endinterface

interface fwh_out_if;
  import fwh_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [INDEX_W-1:0]  bin_index;
  logic [COUNT_W-1:0]  bin_count;
  logic [USED_W-1:0]   bins_in_use;
  logic [INDEX_W-1:0]  fullest_bin;
  logic [COUNT_W-1:0]  fullest_count;
  logic                is_empty;

  modport source (output valid, status, bin_index, bin_count, bins_in_use, fullest_bin,
                  fullest_count, is_empty, input ready);
  modport sink   (input valid, status, bin_index, bin_count, bins_in_use, fullest_bin,
                  fullest_count, is_empty, output ready);
endinterface

// File: hdl/fwh_div.sv
// Serial restoring divider: one quotient bit per cycle.
module fwh_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [fwh_pkg::VALUE_W-1:0] dividend_i,
  input  logic [fwh_pkg::VALUE_W-1:0] divisor_i,
  output logic                        done_o,
  output logic [fwh_pkg::VALUE_W-1:0] quotient_o
);
  import fwh_pkg::*;

  localparam int CNT_W = $clog2(VALUE_W);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [VALUE_W-1:0] rem_q, quo_q, dvs_q;
  logic [VALUE_W:0]   rem_sh;
  logic               fits;

  // Shift in the next dividend bit and try the subtract
  assign rem_sh = {rem_q, quo_q[VALUE_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs_q};

  // Control: busy for VALUE_W steps, done pulse after the last one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(VALUE_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Operand and partial remainder registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? VALUE_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[VALUE_W-1:0];
      quo_q <= {quo_q[VALUE_W-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// File: hdl/fwh_datapath.sv
// Histogram datapath: item latch, divider, bin store, mode tracking, result register.
module fwh_datapath #(
  parameter int NUM_BINS    = fwh_pkg::NUM_BINS_DEF,
  parameter int COUNT_WIDTH = fwh_pkg::COUNT_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  fwh_pkg::cmd_t                cmd_i,
  output fwh_pkg::stat_t               stat_o,
  input  logic [fwh_pkg::OPCODE_W-1:0] opcode_i,
  input  logic [fwh_pkg::VALUE_W-1:0]  sample_value_i,
  input  logic [fwh_pkg::RDBIN_W-1:0]  read_bin_i,
  input  logic [fwh_pkg::APB_DW-1:0]   bin_width_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [fwh_pkg::STATUS_W-1:0] status_o,
  output logic [fwh_pkg::INDEX_W-1:0]  bin_index_o,
  output logic [fwh_pkg::COUNT_W-1:0]  bin_count_o,
  output logic [fwh_pkg::USED_W-1:0]   bins_in_use_o,
  output logic [fwh_pkg::INDEX_W-1:0]  fullest_bin_o,
  output logic [fwh_pkg::COUNT_W-1:0]  fullest_count_o,
  output logic                         is_empty_o
);
  import fwh_pkg::*;

  localparam int IW = $clog2(NUM_BINS);
  localparam int UW = $clog2(NUM_BINS + 1);
  localparam int CW = COUNT_WIDTH;
  localparam logic [CW-1:0] COUNT_MAX = '1;

  // Latched item
  logic [OPCODE_W-1:0] op_q;
  logic [VALUE_W-1:0]  value_q;
  logic [RDBIN_W-1:0]  rd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= opcode_i;
      value_q <= sample_value_i;
      rd_q    <= read_bin_i;
    end
  end

  // Bin index by serial division; a zero width counts as one
  logic               div_done;
  logic [VALUE_W-1:0] quo, divisor;
  logic [IW-1:0]      idx, rd_addr;

  assign divisor = (bin_width_i == '0) ? VALUE_W'(1) : bin_width_i;

  fwh_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (value_q),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  assign idx     = IW'(quo);
  assign rd_addr = IW'(rd_q);

  // Clearing sweep counter
  logic [IW-1:0] sweep_cnt_q;
  logic          sweep_last;

  assign sweep_last = sweep_cnt_q == IW'(NUM_BINS - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_cnt_q <= '0;
    end else if (cmd_i.sweep) begin
      sweep_cnt_q <= sweep_last ? '0 : sweep_cnt_q + 1'b1;
    end
  end

  // Increment, saturation and mode compare
  logic [CW-1:0] rdata_q, c_new;
  logic          sat, mode_take, used_hit;
  logic [UW-1:0] used_q, used_nx;
  logic [IW-1:0] mode_index_q, mode_index_nx;
  logic [CW-1:0] mode_count_q, mode_count_nx;

  assign sat       = rdata_q == COUNT_MAX;
  assign c_new     = sat ? rdata_q : rdata_q + 1'b1;
  assign mode_take = !sat && ((c_new > mode_count_q) ||
                              ((c_new == mode_count_q) && (idx < mode_index_q)));
  assign used_hit  = UW'(idx) >= used_q;
  assign used_nx   = used_hit ? UW'(idx) + UW'(1) : used_q;
  assign mode_index_nx = mode_take ? idx : mode_index_q;
  assign mode_count_nx = mode_take ? c_new : mode_count_q;

  // Bin store: one write port, one registered read port
  logic [CW-1:0] mem [NUM_BINS];
  logic          mem_we;
  logic [IW-1:0] mem_waddr, mem_raddr;
  logic [CW-1:0] mem_wdata;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx;
    mem_wdata = c_new;
    if (cmd_i.sweep) begin
      mem_we    = 1'b1;
      mem_waddr = sweep_cnt_q;
      mem_wdata = '0;
    end else if (cmd_i.upd && !sat) begin
      mem_we = 1'b1;
    end
  end

  assign mem_raddr = cmd_i.rd_sel_read ? rd_addr : idx;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.mem_rd) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  // Summary state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q       <= '0;
      mode_index_q <= '0;
      mode_count_q <= '0;
    end else if (cmd_i.clr_state) begin
      used_q       <= '0;
      mode_index_q <= '0;
      mode_count_q <= '0;
    end else if (cmd_i.upd) begin
      used_q       <= used_nx;
      mode_index_q <= mode_index_nx;
      mode_count_q <= mode_count_nx;
    end
  end

  // Result selection
  logic          rd_unused;
  status_e       res_status;
  logic [IW-1:0] res_idx;
  logic [RDBIN_W-1:0] res_rd;
  logic          res_use_rd;
  logic [CW-1:0] res_count, res_mode_count;
  logic [UW-1:0] res_used;
  logic [IW-1:0] res_mode_index;

  assign rd_unused = (32'(rd_q) >= 32'(used_q)) || (32'(rd_q) >= 32'(NUM_BINS));

  always_comb begin
    res_status     = cmd_i.res_status;
    res_idx        = '0;
    res_rd         = rd_q;
    res_use_rd     = 1'b0;
    res_count      = '0;
    res_used       = used_q;
    res_mode_index = mode_index_q;
    res_mode_count = mode_count_q;
    case (cmd_i.res_kind)
      RES_INS: begin
        res_status     = ST_OK;
        res_idx        = idx;
        res_count      = c_new;
        res_used       = used_nx;
        res_mode_index = mode_index_nx;
        res_mode_count = mode_count_nx;
      end
      RES_READ: begin
        res_status = rd_unused ? ST_UNUSED : ST_OK;
        res_use_rd = 1'b1;
        res_count  = rd_unused ? '0 : rdata_q;
      end
      default: begin
      end
    endcase
  end

  // Output register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      status_o        <= res_status;
      bin_index_o     <= res_use_rd ? res_rd : INDEX_W'(res_idx);
      bin_count_o     <= COUNT_W'(res_count);
      bins_in_use_o   <= USED_W'(res_used);
      fullest_bin_o   <= INDEX_W'(res_mode_index);
      fullest_count_o <= COUNT_W'(res_mode_count);
      is_empty_o      <= res_used == '0;
    end
  end

  assign out_valid_o = out_valid_q;

  // Status to the controller
  assign stat_o.op         = op_q;
  assign stat_o.neg        = value_q[VALUE_W-1];
  assign stat_o.div_done   = div_done;
  assign stat_o.beyond     = quo >= 32'(NUM_BINS);
  assign stat_o.sweep_last = sweep_last;
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

endmodule

// File: hdl/fwh_ctrl.sv
// Histogram controller: sequences clear sweeps, division, bin reads and bin updates.
module fwh_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  fwh_pkg::stat_t stat_i,
  output fwh_pkg::cmd_t  cmd_o
);
  import fwh_pkg::*;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_DISP,
    S_DIV,
    S_UPD,
    S_RRES,
    S_CLR,
    S_EMIT
  } state_e;

  state_e  state_q, state_d;
  status_e st_q, st_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    st_d    = st_q;
    cmd_o   = '0;
    unique case (state_q)
      S_INIT: begin
        cmd_o.sweep = 1'b1;
        if (stat_i.sweep_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DISP;
        end
      end
      S_DISP: begin
        unique case (stat_i.op)
          OP_INSERT: begin
            if (stat_i.neg) begin
              st_d    = ST_NEG;
              state_d = S_EMIT;
            end else begin
              cmd_o.div_start = 1'b1;
              state_d         = S_DIV;
            end
          end
          OP_CLEAR: begin
            cmd_o.clr_state = 1'b1;
            state_d         = S_CLR;
          end
          OP_READ: begin
            cmd_o.mem_rd      = 1'b1;
            cmd_o.rd_sel_read = 1'b1;
            state_d           = S_RRES;
          end
          default: begin
            st_d    = ST_OK;
            state_d = S_EMIT;
          end
        endcase
      end
      S_DIV: begin
        if (stat_i.div_done) begin
          if (stat_i.beyond) begin
            st_d    = ST_BEYOND;
            state_d = S_EMIT;
          end else begin
            cmd_o.mem_rd = 1'b1;
            state_d      = S_UPD;
          end
        end
      end
      S_UPD: begin
        if (stat_i.out_free) begin
          cmd_o.upd      = 1'b1;
          cmd_o.res_load = 1'b1;
          cmd_o.res_kind = RES_INS;
          state_d        = S_IDLE;
        end
      end
      S_RRES: begin
        if (stat_i.out_free) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_kind = RES_READ;
          state_d        = S_IDLE;
        end
      end
      S_CLR: begin
        cmd_o.sweep = 1'b1;
        if (stat_i.sweep_last) begin
          st_d    = ST_OK;
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_kind   = RES_FLAG;
          cmd_o.res_status = st_q;
          state_d          = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State and registered status code
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      st_q    <= ST_OK;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
    end
  end

  assign in_ready_o = state_q == S_IDLE;

endmodule

// File: hdl/fixed_width_histogram_engine_top.sv
// Equal-width histogram engine: one item at a time through a serial divider
// and a read-modify-write of the bin store. Before the next ready, an insert
// passes through dispatch, the divider steps, the bin read and the update, a
// read through dispatch and the bin read, and a clear through a sweep that
// zeroes the bin store one entry per cycle. After reset the same sweep runs
// before the first item is accepted; register writes are taken at any time.
// A finished result waits in an output register and does not hold up
// acceptance of the next item. The bin width register lies at byte address 0.
module fixed_width_histogram_engine_top #(
  parameter int NUM_BINS    = fwh_pkg::NUM_BINS_DEF,
  parameter int COUNT_WIDTH = fwh_pkg::COUNT_WIDTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  fwh_in_if.sink                     item_i,
  fwh_out_if.source                  result_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [fwh_pkg::APB_AW-1:0] paddr,
  input  logic [fwh_pkg::APB_DW-1:0] pwdata,
  output logic [fwh_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);
  import fwh_pkg::*;

  // Configuration register
  logic [APB_DW-1:0] bin_width_q;
  logic              reg_sel;

  assign reg_sel = paddr[2] == REG_BIN_WIDTH;
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? bin_width_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_width_q <= BIN_WIDTH_RST;
    end else if (psel && penable && pwrite && reg_sel) begin
      bin_width_q <= pwdata;
    end
  end

  // Controller and datapath
  cmd_t  cmd;
  stat_t stat;
  logic  in_ready;
  logic  out_valid;

  fwh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  fwh_datapath #(
    .NUM_BINS    (NUM_BINS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .opcode_i        (item_i.opcode),
    .sample_value_i  (item_i.sample_value),
    .read_bin_i      (item_i.read_bin),
    .bin_width_i     (bin_width_q),
    .out_valid_o     (out_valid),
    .out_ready_i     (result_o.ready),
    .status_o        (result_o.status),
    .bin_index_o     (result_o.bin_index),
    .bin_count_o     (result_o.bin_count),
    .bins_in_use_o   (result_o.bins_in_use),
    .fullest_bin_o   (result_o.fullest_bin),
    .fullest_count_o (result_o.fullest_count),
    .is_empty_o      (result_o.is_empty)
  );

  assign item_i.ready   = in_ready;
  assign result_o.valid = out_valid;

endmodule
